// ===== hdl/ckrd_pkg.sv =====
// shared types, constants and the crc-8 byte update for the keymap record decoder
`default_nettype none
package ckrd_pkg;

    localparam int BUTTON_COUNT_DEF = 3;
    localparam int BYTE_W           = 8;
    localparam int CFG_INDEX_W      = 1;
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_TOP  = 8'h80;
    localparam logic [7:0] MARKER_RESET  = 8'h00;
    localparam logic [7:0] MAX_KEY_RESET = 8'hFF;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_BAD_LEN  = 3'd1,
        STATUS_BAD_MARK = 3'd2,
        STATUS_BAD_CRC  = 3'd3,
        STATUS_BAD_CHORD = 3'd4
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RECORD_MARKER = 1'd0,
        REG_MAX_KEY_CODE  = 1'd1
    } cfg_index_t;

    typedef struct packed {
        logic length_ok;
        logic marker_ok;
        logic crc_ok;
    } frame_flags_t;

    function automatic byte_t crc8_feed(input byte_t crc, input byte_t b);
        byte_t c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if ((c & CRC_TOP) != 8'h00) begin
                c = (c << 1) ^ CRC_POLY;
            end
            else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ckrd_if.sv =====
// valid/ready channel interfaces for record bytes, results and register writes
`default_nettype none
interface ckrd_byte_if;
    logic                valid;
    logic                ready;
    ckrd_pkg::byte_t     data_byte;
    logic                final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface ckrd_result_if;
    logic                valid;
    logic                ready;
    ckrd_pkg::status_t   status;
    ckrd_pkg::byte_t     mods_first;
    ckrd_pkg::byte_t     key_first;
    ckrd_pkg::byte_t     mods_second;
    ckrd_pkg::byte_t     key_second;
    ckrd_pkg::byte_t     mods_third;
    ckrd_pkg::byte_t     key_third;

    modport source (output valid, output status, output mods_first, output key_first,
                    output mods_second, output key_second, output mods_third,
                    output key_third, input ready);
    modport sink   (input valid, input status, input mods_first, input key_first,
                    input mods_second, input key_second, input mods_third,
                    input key_third, output ready);
endinterface

interface ckrd_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [ckrd_pkg::CFG_INDEX_W-1:0]       index;
    ckrd_pkg::byte_t                        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/ckrd_frame_track.sv =====
// per-record byte count, running crc, marker and checksum flags and payload store
`default_nettype none
module ckrd_frame_track #(
    parameter int BUTTON_COUNT = ckrd_pkg::BUTTON_COUNT_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire ckrd_pkg::byte_t        data_byte,
    input  wire logic                   final_byte,
    input  wire ckrd_pkg::byte_t        record_marker,
    output ckrd_pkg::frame_flags_t      flags,
    output ckrd_pkg::byte_t             payload [2*BUTTON_COUNT]
);

    localparam int PAYLOAD_BYTES = 2 * BUTTON_COUNT;
    localparam int RECORD_BYTES  = PAYLOAD_BYTES + 2;
    localparam int CRC_COVER     = RECORD_BYTES - 1;
    localparam int COUNT_SAT     = RECORD_BYTES + 1;
    localparam int COUNT_W       = $clog2(COUNT_SAT + 1);
    localparam int PIDX_W        = $clog2(PAYLOAD_BYTES);

    logic [COUNT_W-1:0] count_reg, count_next, count_inc;
    ckrd_pkg::byte_t    crc_reg, crc_next, crc_upd;
    logic               marker_reg, marker_next, marker_upd;
    logic               match_reg, match_next, match_upd;
    logic [COUNT_W-1:0] pidx;
    logic               pwrite;
    ckrd_pkg::byte_t    payload_reg [PAYLOAD_BYTES];

    always_comb
    begin
        count_inc  = (count_reg < COUNT_W'(COUNT_SAT)) ? count_reg + 1'b1 : count_reg;
        marker_upd = (count_reg == '0) ? (data_byte == record_marker) : marker_reg;
        crc_upd    = (count_reg < COUNT_W'(CRC_COVER)) ?
                     ckrd_pkg::crc8_feed(crc_reg, data_byte) : crc_reg;
        match_upd  = (count_reg == COUNT_W'(CRC_COVER)) ? (data_byte == crc_reg) : match_reg;
        pidx       = count_reg - 1'b1;
        pwrite     = accept && (count_reg >= COUNT_W'(1))
                     && (count_reg <= COUNT_W'(PAYLOAD_BYTES));

        flags.length_ok = (count_inc == COUNT_W'(RECORD_BYTES));
        flags.marker_ok = marker_upd;
        flags.crc_ok    = match_upd;

        count_next  = count_reg;
        crc_next    = crc_reg;
        marker_next = marker_reg;
        match_next  = match_reg;
        if (accept) begin
            if (final_byte) begin
                count_next  = '0;
                crc_next    = '0;
                marker_next = 1'b0;
                match_next  = 1'b0;
            end
            else begin
                count_next  = count_inc;
                crc_next    = crc_upd;
                marker_next = marker_upd;
                match_next  = match_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg  <= '0;
            crc_reg    <= '0;
            marker_reg <= 1'b0;
            match_reg  <= 1'b0;
        end
        else begin
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            marker_reg <= marker_next;
            match_reg  <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pwrite) begin
            payload_reg[pidx[PIDX_W-1:0]] <= data_byte;
        end
    end

    assign payload = payload_reg;

endmodule
`default_nettype wire

// ===== hdl/crc8_keymap_record_decoder.sv =====
// top level of the crc-8 checked keymap record decoder
// latency: one result word appears in the cycle after the final byte is taken
// throughput: one byte word per cycle while no result waits on tx.ready; state update and checks sit between
//   the byte handshake and the result register
// reset: record state cleared, record_marker 0, max_key_code 255, no result pending
`default_nettype none
module crc8_keymap_record_decoder #(
    parameter int BUTTON_COUNT = ckrd_pkg::BUTTON_COUNT_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ckrd_byte_if.sink    rx,
    ckrd_result_if.source tx,
    ckrd_cfg_if.sink     cfg
);

    localparam int PAYLOAD_BYTES = 2 * BUTTON_COUNT;

    ckrd_pkg::byte_t       marker_reg;
    ckrd_pkg::byte_t       max_key_reg;
    ckrd_pkg::frame_flags_t flags;
    ckrd_pkg::byte_t       payload [PAYLOAD_BYTES];
    ckrd_pkg::status_t     status;
    logic                  accept;
    logic                  chord_bad;

    logic                  out_valid_reg, out_valid_next;
    ckrd_pkg::status_t     status_reg;
    ckrd_pkg::byte_t       field_reg [PAYLOAD_BYTES];

    assign rx.ready  = !out_valid_reg || tx.ready;
    assign accept    = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    ckrd_frame_track #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_track (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (rx.data_byte),
        .final_byte    (rx.final_byte),
        .record_marker (marker_reg),
        .flags         (flags),
        .payload       (payload)
    );

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            marker_reg  <= ckrd_pkg::MARKER_RESET;
            max_key_reg <= ckrd_pkg::MAX_KEY_RESET;
        end
        else if (cfg.valid) begin
            case (ckrd_pkg::cfg_index_t'(cfg.index))
                ckrd_pkg::REG_RECORD_MARKER: marker_reg  <= cfg.data;
                ckrd_pkg::REG_MAX_KEY_CODE:  max_key_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        chord_bad = 1'b0;
        for (int j = 0; j < BUTTON_COUNT; j++) begin
            if ((payload[2*j+1] > max_key_reg)
                || ((payload[2*j] == '0) && (payload[2*j+1] == '0))) begin
                chord_bad = 1'b1;
            end
        end
        if (!flags.length_ok) begin
            status = ckrd_pkg::STATUS_BAD_LEN;
        end
        else if (!flags.marker_ok) begin
            status = ckrd_pkg::STATUS_BAD_MARK;
        end
        else if (!flags.crc_ok) begin
            status = ckrd_pkg::STATUS_BAD_CRC;
        end
        else if (chord_bad) begin
            status = ckrd_pkg::STATUS_BAD_CHORD;
        end
        else begin
            status = ckrd_pkg::STATUS_OK;
        end

        out_valid_next = out_valid_reg;
        if (accept && rx.final_byte) begin
            out_valid_next = 1'b1;
        end
        else if (tx.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && rx.final_byte) begin
            status_reg <= status;
            for (int j = 0; j < PAYLOAD_BYTES; j++) begin
                field_reg[j] <= (status == ckrd_pkg::STATUS_OK) ? payload[j] : '0;
            end
        end
    end

    assign tx.valid       = out_valid_reg;
    assign tx.status      = status_reg;
    assign tx.mods_first  = field_reg[0];
    assign tx.key_first   = field_reg[1];
    assign tx.mods_second = field_reg[2];
    assign tx.key_second  = field_reg[3];
    assign tx.mods_third  = field_reg[4];
    assign tx.key_third   = field_reg[5];

endmodule
`default_nettype wire
